/* design/c2csr_pkg.sv */
// ----------------------------------------------------------------------------
// c2csr_pkg : shared definitions for the block COO-to-CSR converter
// Item kinds, result sections, register indexes, default sizes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package c2csr_pkg;

    // Default sizes
    localparam int MAX_ENTRIES_DEF   = 256;
    localparam int MAX_BLOCK_DIM_DEF = 8;
    localparam int MAX_DIM_DEF       = 4096;

    // Fixed field widths
    localparam int NROWS_W = 13;
    localparam int BDIM_W  = 4;
    localparam int COORD_W = 12;
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 2;
    localparam int SEC_W   = 2;
    localparam int CIDX_W  = 2;

    // Reset values of the registers
    localparam logic [NROWS_W-1:0] NUM_ROWS_RST  = NROWS_W'(4096);
    localparam logic [BDIM_W-1:0]  BLOCK_DIM_RST = BDIM_W'(1);

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

    // Result sections
    localparam logic [SEC_W-1:0] SEC_ROW_PTR = 2'd0;
    localparam logic [SEC_W-1:0] SEC_COL_IDX = 2'd1;
    localparam logic [SEC_W-1:0] SEC_VALUE   = 2'd2;
    localparam logic [SEC_W-1:0] SEC_STATUS  = 2'd3;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCK_DIM = 2'd1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SORT_NEXT,
        ST_SORT_KEY,
        ST_SORT_CHECK,
        ST_SORT_SLOT,
        ST_SORT_CMP,
        ST_RD_DIV,
        ST_RD_TOTAL,
        ST_RD_CHECK,
        ST_PTR_CHECK,
        ST_PTR_SLOT,
        ST_PTR_CMP,
        ST_PTR_EMIT,
        ST_COL_SLOT,
        ST_COL_EMIT,
        ST_VAL_DIV,
        ST_VAL_SLOT,
        ST_VAL_WORD,
        ST_VAL_EMIT
    } state_t;

endpackage

/* design/block_coo_to_csr_converter.sv */
// ----------------------------------------------------------------------------
// block_coo_to_csr_converter : block-sparse COO to CSR conversion
// Loads block entries (header plus block words), sorts them by row then
// column with ties in load order, and streams the compressed form.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes items: tuser = kind (header, value, convert, read).
//   Header and value items load the tables.
//   A convert item runs an insertion sort over the slot table and
//   answers one status item with the entry count.
//   A read item answers one word: row pointers, column indices, then
//   block words. Each read after a convert runs the shared bit-serial
//   divider once for the row-pointer count; a value word runs it a
//   second time to split the position into entry and word. A row-pointer
//   word also scans the sorted entries that its cursor passes. Before a
//   convert, or past the end, a read answers one status item instead.
//   One item is in work at a time; s_tready stays low while an item is
//   in work or a result waits in the output register.
//   cfg_* writes num_rows (index 0) or block_dim (index 1), always ready.
//   Reset (aresetn low, synchronous) empties the tables, clears the
//   error flag and loads num_rows 4096, block_dim 1. A stalled m_tready
//   holds the result and the block takes no further item.
module block_coo_to_csr_converter #(
    parameter int MAX_ENTRIES   = c2csr_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_BLOCK_DIM = c2csr_pkg::MAX_BLOCK_DIM_DEF,
    parameter int MAX_DIM       = c2csr_pkg::MAX_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // row_index[11:0], col_index[23:12], value[55:24]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data[31:0], error[32], zero fill[39:33]
    output logic [1:0]  m_tuser,   // section[1:0]
    output logic        m_tlast,   // is_last
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [c2csr_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [c2csr_pkg::NROWS_W-1:0] cfg_data
);

    localparam int BLOCK_SLOT  = MAX_BLOCK_DIM * MAX_BLOCK_DIM;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SD_W        = $clog2(MAX_BLOCK_DIM + 1);
    localparam int BS_W        = $clog2(BLOCK_SLOT + 1);
    localparam int WA_W        = (BLOCK_SLOT > 1) ? $clog2(BLOCK_SLOT) : 1;
    localparam int POS_W       = $clog2((2 ** c2csr_pkg::NROWS_W) + 1
                                        + MAX_ENTRIES * (BLOCK_SLOT + 1));
    localparam int DC_W        = $clog2(POS_W);
    localparam int LIM_W       = POS_W + SD_W;
    localparam int KEY_W       = 2 * c2csr_pkg::COORD_W;
    localparam int WORDS_DEPTH = MAX_ENTRIES * (2 ** WA_W);
    localparam int CW          = c2csr_pkg::COORD_W;

    // Control and configuration registers
    c2csr_pkg::state_t state_reg, state_next;
    logic [c2csr_pkg::NROWS_W-1:0] num_rows_reg;
    logic [c2csr_pkg::BDIM_W-1:0]  block_dim_reg;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [BS_W-1:0]  word_count_reg, word_count_next;
    logic             reading_reg, reading_next;
    logic [POS_W-1:0] read_pos_reg, read_pos_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic             error_reg, error_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0] dq_reg, dq_next;
    logic [BS_W:0]    rem_reg, rem_next;
    logic [BS_W-1:0]  div_reg, div_next;
    logic [DC_W-1:0]  dcnt_reg, dcnt_next;
    logic [POS_W-1:0] nptr_reg, nptr_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [LIM_W-1:0] limit_reg, limit_next;
    logic             last_reg, last_next;

    // Output register
    logic                         m_valid_reg;
    logic [c2csr_pkg::SEC_W-1:0]  m_sec_reg;
    logic [c2csr_pkg::WORD_W-1:0] m_data_reg;
    logic                         m_last_reg;
    logic                         m_err_reg;
    logic                         out_load;
    logic [c2csr_pkg::SEC_W-1:0]  out_sec;
    logic [c2csr_pkg::WORD_W-1:0] out_data;
    logic                         out_last;

    // Memories and their ports
    logic [CW-1:0]    rows_mem [0:MAX_ENTRIES-1];
    logic [CW-1:0]    cols_mem [0:MAX_ENTRIES-1];
    logic [IDX_W-1:0] slots_mem [0:MAX_ENTRIES-1];
    logic [c2csr_pkg::WORD_W-1:0] words_mem [0:WORDS_DEPTH-1];
    logic [CW-1:0]    rows_q, cols_q;
    logic [IDX_W-1:0] slots_q;
    logic [c2csr_pkg::WORD_W-1:0] words_q;
    logic             ent_we, slot_we, word_we;
    logic [IDX_W-1:0] ent_waddr, ent_raddr, slot_waddr, slot_raddr, slot_wdata;
    logic [CW-1:0]    ent_wrow, ent_wcol;
    logic [IDX_W+WA_W-1:0] word_waddr, word_raddr;
    logic [c2csr_pkg::WORD_W-1:0] word_wdata;

    // Input unpacking and derived values
    logic                          s_acc;
    logic [c2csr_pkg::KIND_W-1:0]  in_kind;
    logic [CW-1:0]                 in_row, in_col;
    logic [c2csr_pkg::WORD_W-1:0]  in_value;
    logic [SD_W-1:0]               side;
    logic [BS_W-1:0]               bs;
    logic [BS_W:0]                 div_shift;
    logic                          div_qbit;
    logic [BS_W:0]                 rem_step;
    logic [POS_W-1:0]              dq_step;
    logic [CNT_W-1:0]              ec_v;
    logic [BS_W-1:0]               wc_v;
    logic [CNT_W-1:0]              ec_m1;
    logic [POS_W-1:0]              p_col, p_val;

    assign s_acc    = s_tvalid && s_tready;
    assign in_kind  = s_tuser;
    assign in_row   = s_tdata[11:0];
    assign in_col   = s_tdata[23:12];
    assign in_value = s_tdata[55:24];

    assign s_tready  = (state_reg == c2csr_pkg::ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, m_err_reg, m_data_reg};
    assign m_tuser   = m_sec_reg;
    assign m_tlast   = m_last_reg;

    // Clamp the block side and form the block size
    always_comb begin
        if (block_dim_reg == '0) begin
            side = SD_W'(1);
        end else if (32'(block_dim_reg) > MAX_BLOCK_DIM) begin
            side = SD_W'(MAX_BLOCK_DIM);
        end else begin
            side = SD_W'(block_dim_reg);
        end
        bs = BS_W'(side) * BS_W'(side);
    end

    // Shared restoring divider, one quotient bit per cycle
    always_comb begin
        div_shift = {rem_reg[BS_W-1:0], dq_reg[POS_W-1]};
        div_qbit  = (div_shift >= {1'b0, div_reg});
        rem_step  = div_qbit ? (div_shift - {1'b0, div_reg}) : div_shift;
        dq_step   = {dq_reg[POS_W-2:0], div_qbit};
    end

    assign p_col = read_pos_reg - nptr_reg;
    assign p_val = read_pos_reg - nptr_reg - POS_W'(entry_count_reg);

    // Sequencer: next state, table writes and result
    always_comb begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        word_count_next  = word_count_reg;
        reading_next     = reading_reg;
        read_pos_next    = read_pos_reg;
        cursor_next      = cursor_reg;
        error_next       = error_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        key_next         = key_reg;
        slot_next        = slot_reg;
        dq_next          = dq_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        dcnt_next        = dcnt_reg;
        nptr_next        = nptr_reg;
        total_next       = total_reg;
        limit_next       = limit_reg;
        last_next        = last_reg;
        out_load         = 1'b0;
        out_sec          = c2csr_pkg::SEC_STATUS;
        out_data         = '0;
        out_last         = 1'b0;
        ent_we           = 1'b0;
        ent_waddr        = '0;
        ent_wrow         = in_row;
        ent_wcol         = in_col;
        ent_raddr        = '0;
        slot_we          = 1'b0;
        slot_waddr       = '0;
        slot_wdata       = '0;
        slot_raddr       = '0;
        word_we          = 1'b0;
        word_waddr       = '0;
        word_wdata       = in_value;
        word_raddr       = '0;
        ec_v             = entry_count_reg;
        wc_v             = word_count_reg;
        ec_m1            = entry_count_reg - CNT_W'(1);

        case (state_reg)
            c2csr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (in_kind)
                        c2csr_pkg::KIND_HEADER: begin
                            // a header while reading starts a fresh load
                            if (reading_reg) begin
                                ec_v         = '0;
                                wc_v         = '0;
                                error_next   = 1'b0;
                                reading_next = 1'b0;
                            end
                            if (ec_v != '0 && wc_v != bs) begin
                                error_next = 1'b1;
                            end
                            if (32'(ec_v) >= MAX_ENTRIES) begin
                                // drop on table overflow
                                error_next       = 1'b1;
                                entry_count_next = ec_v;
                                word_count_next  = bs;
                            end else begin
                                if ({1'b0, in_row} >= num_rows_reg
                                    || 32'(in_row) >= MAX_DIM) begin
                                    error_next = 1'b1;
                                end
                                ent_we           = 1'b1;
                                ent_waddr        = ec_v[IDX_W-1:0];
                                entry_count_next = ec_v + CNT_W'(1);
                                word_count_next  = '0;
                            end
                        end
                        c2csr_pkg::KIND_VALUE: begin
                            if (reading_reg || entry_count_reg == '0
                                || word_count_reg >= bs) begin
                                error_next = 1'b1;
                            end else begin
                                word_we         = 1'b1;
                                word_waddr      = {ec_m1[IDX_W-1:0],
                                                   word_count_reg[WA_W-1:0]};
                                word_count_next = word_count_reg + BS_W'(1);
                            end
                        end
                        c2csr_pkg::KIND_CONVERT: begin
                            if (entry_count_reg != '0 && word_count_reg != bs) begin
                                error_next = 1'b1;
                            end
                            reading_next  = 1'b1;
                            read_pos_next = '0;
                            cursor_next   = '0;
                            i_next        = '0;
                            state_next    = c2csr_pkg::ST_SORT_NEXT;
                        end
                        c2csr_pkg::KIND_READ: begin
                            if (!reading_reg) begin
                                out_load = 1'b1;
                                out_sec  = c2csr_pkg::SEC_STATUS;
                                out_data = 32'(entry_count_reg);
                            end else begin
                                // rows / side, plus one, gives the pointer count
                                dq_next    = POS_W'(num_rows_reg);
                                rem_next   = '0;
                                div_next   = BS_W'(side);
                                dcnt_next  = '0;
                                state_next = c2csr_pkg::ST_RD_DIV;
                            end
                        end
                        default: begin
                            state_next = c2csr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Insertion sort over the slot table
            c2csr_pkg::ST_SORT_NEXT: begin
                if (i_reg >= entry_count_reg) begin
                    out_load   = 1'b1;
                    out_sec    = c2csr_pkg::SEC_STATUS;
                    out_data   = 32'(entry_count_reg);
                    state_next = c2csr_pkg::ST_IDLE;
                end else begin
                    ent_raddr  = i_reg[IDX_W-1:0];
                    state_next = c2csr_pkg::ST_SORT_KEY;
                end
            end
            c2csr_pkg::ST_SORT_KEY: begin
                key_next   = {rows_q, cols_q};
                j_next     = i_reg;
                state_next = c2csr_pkg::ST_SORT_CHECK;
            end
            c2csr_pkg::ST_SORT_CHECK: begin
                if (j_reg == '0) begin
                    slot_we    = 1'b1;
                    slot_waddr = '0;
                    slot_wdata = i_reg[IDX_W-1:0];
                    i_next     = i_reg + CNT_W'(1);
                    state_next = c2csr_pkg::ST_SORT_NEXT;
                end else begin
                    slot_raddr = IDX_W'(j_reg - CNT_W'(1));
                    state_next = c2csr_pkg::ST_SORT_SLOT;
                end
            end
            c2csr_pkg::ST_SORT_SLOT: begin
                slot_next  = slots_q;
                ent_raddr  = slots_q;
                state_next = c2csr_pkg::ST_SORT_CMP;
            end
            c2csr_pkg::ST_SORT_CMP: begin
                slot_we    = 1'b1;
                slot_waddr = j_reg[IDX_W-1:0];
                if ({rows_q, cols_q} > key_reg) begin
                    // shift the larger entry up one place
                    slot_wdata = slot_reg;
                    j_next     = j_reg - CNT_W'(1);
                    state_next = c2csr_pkg::ST_SORT_CHECK;
                end else begin
                    slot_wdata = i_reg[IDX_W-1:0];
                    i_next     = i_reg + CNT_W'(1);
                    state_next = c2csr_pkg::ST_SORT_NEXT;
                end
            end

            // Read: pointer count, then position decode
            c2csr_pkg::ST_RD_DIV: begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(POS_W - 1)) begin
                    state_next = c2csr_pkg::ST_RD_TOTAL;
                end
            end
            c2csr_pkg::ST_RD_TOTAL: begin
                nptr_next  = dq_reg + POS_W'(1);
                total_next = dq_reg + POS_W'(1) + POS_W'(entry_count_reg)
                             + POS_W'(entry_count_reg) * POS_W'(bs);
                state_next = c2csr_pkg::ST_RD_CHECK;
            end
            c2csr_pkg::ST_RD_CHECK: begin
                if (read_pos_reg >= total_reg) begin
                    out_load   = 1'b1;
                    out_sec    = c2csr_pkg::SEC_STATUS;
                    out_data   = 32'(entry_count_reg);
                    state_next = c2csr_pkg::ST_IDLE;
                end else begin
                    last_next     = (read_pos_reg == total_reg - POS_W'(1));
                    read_pos_next = read_pos_reg + POS_W'(1);
                    if (read_pos_reg < nptr_reg) begin
                        if (read_pos_reg == '0) begin
                            cursor_next = '0;
                            out_load    = 1'b1;
                            out_sec     = c2csr_pkg::SEC_ROW_PTR;
                            out_data    = '0;
                            out_last    = last_next;
                            state_next  = c2csr_pkg::ST_IDLE;
                        end else begin
                            limit_next = LIM_W'(side)
                                         * LIM_W'(read_pos_reg - POS_W'(1));
                            state_next = c2csr_pkg::ST_PTR_CHECK;
                        end
                    end else if (p_col < POS_W'(entry_count_reg)) begin
                        slot_raddr = p_col[IDX_W-1:0];
                        state_next = c2csr_pkg::ST_COL_SLOT;
                    end else begin
                        // split into entry and word
                        dq_next    = p_val;
                        rem_next   = '0;
                        div_next   = bs;
                        dcnt_next  = '0;
                        state_next = c2csr_pkg::ST_VAL_DIV;
                    end
                end
            end

            // Row pointer: advance the cursor past rows within the limit
            c2csr_pkg::ST_PTR_CHECK: begin
                if (cursor_reg < entry_count_reg) begin
                    slot_raddr = cursor_reg[IDX_W-1:0];
                    state_next = c2csr_pkg::ST_PTR_SLOT;
                end else begin
                    state_next = c2csr_pkg::ST_PTR_EMIT;
                end
            end
            c2csr_pkg::ST_PTR_SLOT: begin
                ent_raddr  = slots_q;
                state_next = c2csr_pkg::ST_PTR_CMP;
            end
            c2csr_pkg::ST_PTR_CMP: begin
                if (LIM_W'(rows_q) <= limit_reg) begin
                    cursor_next = cursor_reg + CNT_W'(1);
                    state_next  = c2csr_pkg::ST_PTR_CHECK;
                end else begin
                    state_next = c2csr_pkg::ST_PTR_EMIT;
                end
            end
            c2csr_pkg::ST_PTR_EMIT: begin
                out_load   = 1'b1;
                out_sec    = c2csr_pkg::SEC_ROW_PTR;
                out_data   = 32'(cursor_reg) * 32'(bs);
                out_last   = last_reg;
                state_next = c2csr_pkg::ST_IDLE;
            end

            // Column index
            c2csr_pkg::ST_COL_SLOT: begin
                ent_raddr  = slots_q;
                state_next = c2csr_pkg::ST_COL_EMIT;
            end
            c2csr_pkg::ST_COL_EMIT: begin
                out_load   = 1'b1;
                out_sec    = c2csr_pkg::SEC_COL_IDX;
                out_data   = 32'(cols_q);
                out_last   = last_reg;
                state_next = c2csr_pkg::ST_IDLE;
            end

            // Block word
            c2csr_pkg::ST_VAL_DIV: begin
                dq_next   = dq_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DC_W'(1);
                if (dcnt_reg == DC_W'(POS_W - 1)) begin
                    state_next = c2csr_pkg::ST_VAL_SLOT;
                end
            end
            c2csr_pkg::ST_VAL_SLOT: begin
                slot_raddr = dq_reg[IDX_W-1:0];
                state_next = c2csr_pkg::ST_VAL_WORD;
            end
            c2csr_pkg::ST_VAL_WORD: begin
                word_raddr = {slots_q, rem_reg[WA_W-1:0]};
                state_next = c2csr_pkg::ST_VAL_EMIT;
            end
            c2csr_pkg::ST_VAL_EMIT: begin
                out_load   = 1'b1;
                out_sec    = c2csr_pkg::SEC_VALUE;
                out_data   = words_q;
                out_last   = last_reg;
                state_next = c2csr_pkg::ST_IDLE;
            end

            default: begin
                state_next = c2csr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= c2csr_pkg::ST_IDLE;
            num_rows_reg    <= c2csr_pkg::NUM_ROWS_RST;
            block_dim_reg   <= c2csr_pkg::BLOCK_DIM_RST;
            entry_count_reg <= '0;
            word_count_reg  <= '0;
            reading_reg     <= 1'b0;
            read_pos_reg    <= '0;
            cursor_reg      <= '0;
            error_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            word_count_reg  <= word_count_next;
            reading_reg     <= reading_next;
            read_pos_reg    <= read_pos_next;
            cursor_reg      <= cursor_next;
            error_reg       <= error_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == c2csr_pkg::REG_NUM_ROWS) begin
                    num_rows_reg <= cfg_data;
                end else if (cfg_index == c2csr_pkg::REG_BLOCK_DIM) begin
                    block_dim_reg <= cfg_data[c2csr_pkg::BDIM_W-1:0];
                end
            end
            // hold the result until taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        dcnt_reg  <= dcnt_next;
        nptr_reg  <= nptr_next;
        total_reg <= total_next;
        limit_reg <= limit_next;
        last_reg  <= last_next;
        if (out_load) begin
            m_sec_reg  <= out_sec;
            m_data_reg <= out_data;
            m_last_reg <= out_last;
            m_err_reg  <= error_next;
        end
    end

    // Entry tables
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            rows_mem[ent_waddr] <= ent_wrow;
            cols_mem[ent_waddr] <= ent_wcol;
        end
        rows_q <= rows_mem[ent_raddr];
        cols_q <= cols_mem[ent_raddr];
    end

    // Sorted slot table
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slots_mem[slot_waddr] <= slot_wdata;
        end
        slots_q <= slots_mem[slot_raddr];
    end

    // Block word store
    always_ff @(posedge aclk) begin
        if (word_we) begin
            words_mem[word_waddr] <= word_wdata;
        end
        words_q <= words_mem[word_raddr];
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for block_coo_to_csr_converter
// Loads block entries through the item stream, converts them and reads the
// compressed form back. A predictor inside the bench computes every result
// word, and a checker compares each result with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOT_W   = 64;       // words reserved per entry
    localparam int TABLE_N  = 256;
    localparam int WD_LIMIT = 400000;   // idle cycles before giving up
    localparam int CFG_W    = c2csr_pkg::NROWS_W;

    typedef struct packed {
        logic [1:0]  section;
        logic [31:0] data;
        logic        is_last;
        logic        error;
    } csr_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [c2csr_pkg::CIDX_W-1:0]  cfg_index;
    logic [c2csr_pkg::NROWS_W-1:0] cfg_data;

    block_coo_to_csr_converter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Converter shadow state
    logic [11:0] sh_rows [TABLE_N];
    logic [11:0] sh_cols [TABLE_N];
    logic [31:0] sh_words [TABLE_N*SLOT_W];
    bit          sh_wrote [TABLE_N*SLOT_W];
    int unsigned sh_order [TABLE_N];
    int unsigned sh_count, sh_wcount, sh_phase, sh_rpos, sh_cursor;
    bit          sh_err;
    int unsigned sh_nrows, sh_bdim;

    csr_word_t   pending_words[$];
    int          fail_cnt;
    int          item_cnt;
    bit          quiet;
    bit          hold_req;
    int          idle_cycles;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_side();
        if (sh_bdim == 0) return 1;
        if (sh_bdim > c2csr_pkg::MAX_BLOCK_DIM_DEF) return c2csr_pkg::MAX_BLOCK_DIM_DEF;
        return sh_bdim;
    endfunction

    function automatic void push_word(logic [1:0] sec, int unsigned d, bit lst);
        csr_word_t w;
        w.section = sec;
        w.data    = d;
        w.is_last = lst;
        w.error   = sh_err;
        pending_words.push_back(w);
    endfunction

    // Stable insertion sort of the loaded entries by {row, col}
    function automatic void sort_table();
        int unsigned i, j, k;
        for (i = 0; i < sh_count; i++) begin
            k = {sh_rows[i], sh_cols[i]};
            j = i;
            while (j > 0 && {sh_rows[sh_order[j-1]], sh_cols[sh_order[j-1]]} > k) begin
                sh_order[j] = sh_order[j-1];
                j--;
            end
            sh_order[j] = i;
        end
    endfunction

    // Compute the result caused by one accepted item
    function automatic void csr_predict(logic [1:0] kind, logic [11:0] row,
                                        logic [11:0] col, logic [31:0] val);
        int unsigned bd, bs, nptr, total, p, lim, e, w, slot;
        bd = eff_side();
        bs = bd * bd;
        case (kind)
            c2csr_pkg::KIND_HEADER: begin
                if (sh_phase != 0) begin
                    sh_count = 0; sh_wcount = 0; sh_err = 0; sh_phase = 0;
                end
                if (sh_count > 0 && sh_wcount != bs) sh_err = 1;
                if (sh_count >= TABLE_N) begin
                    sh_err = 1;
                    sh_wcount = bs;
                end else begin
                    if (row >= sh_nrows) sh_err = 1;
                    sh_rows[sh_count] = row;
                    sh_cols[sh_count] = col;
                    sh_count++;
                    sh_wcount = 0;
                end
            end
            c2csr_pkg::KIND_VALUE: begin
                if (sh_phase != 0 || sh_count == 0 || sh_wcount >= bs) begin
                    sh_err = 1;
                end else begin
                    sh_words[(sh_count-1)*SLOT_W + sh_wcount] = val;
                    sh_wrote[(sh_count-1)*SLOT_W + sh_wcount] = 1;
                    sh_wcount++;
                end
            end
            c2csr_pkg::KIND_CONVERT: begin
                if (sh_count > 0 && sh_wcount != bs) sh_err = 1;
                sort_table();
                sh_phase = 1; sh_rpos = 0; sh_cursor = 0;
                push_word(c2csr_pkg::SEC_STATUS, sh_count, 0);
            end
            default: begin
                nptr  = sh_nrows / bd + 1;
                total = nptr + sh_count + sh_count * bs;
                p     = sh_rpos;
                if (sh_phase != 1 || p >= total) begin
                    push_word(c2csr_pkg::SEC_STATUS, sh_count, 0);
                end else begin
                    sh_rpos = p + 1;
                    if (p < nptr) begin
                        if (p == 0) begin
                            sh_cursor = 0;
                            push_word(c2csr_pkg::SEC_ROW_PTR, 0, p == total - 1);
                        end else begin
                            lim = bd * (p - 1);
                            while (sh_cursor < sh_count && sh_rows[sh_order[sh_cursor]] <= lim)
                                sh_cursor++;
                            push_word(c2csr_pkg::SEC_ROW_PTR, sh_cursor * bs,
                                      p == total - 1);
                        end
                    end else if (p - nptr < sh_count) begin
                        push_word(c2csr_pkg::SEC_COL_IDX, sh_cols[sh_order[p-nptr]],
                                  p == total - 1);
                    end else begin
                        e    = (p - nptr - sh_count) / bs;
                        w    = (p - nptr - sh_count) % bs;
                        slot = sh_order[e % TABLE_N] % TABLE_N;
                        push_word(c2csr_pkg::SEC_VALUE, sh_words[slot*SLOT_W + w],
                                  p == total - 1);
                    end
                end
            end
        endcase
    endfunction

    // Offer one item, with an occasional gap ahead of it
    task automatic send_item(logic [1:0] kind, logic [11:0] row, logic [11:0] col,
                             logic [31:0] val);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {val, col, row};
        do @(posedge aclk); while (!s_tready);
        csr_predict(kind, row, col, val);
        item_cnt++;
    endtask

    // Items whose unused fields carry noise
    task automatic send_header(logic [11:0] row, logic [11:0] col);
        send_item(c2csr_pkg::KIND_HEADER, row, col, $urandom);
    endtask

    task automatic send_value(logic [31:0] val);
        send_item(c2csr_pkg::KIND_VALUE, 12'($urandom), 12'($urandom), val);
    endtask

    task automatic send_ctrl(logic [1:0] kind);
        send_item(kind, 12'($urandom), 12'($urandom), $urandom);
    endtask

    // Hold the sender until every expected word has come
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [c2csr_pkg::CIDX_W-1:0] idx, int unsigned d);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(d);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == c2csr_pkg::REG_NUM_ROWS) sh_nrows = d & 13'h1FFF;
        else sh_bdim = d & 4'hF;
    endtask

    task automatic set_shape(int unsigned nrows, int unsigned bdim);
        write_reg(c2csr_pkg::REG_NUM_ROWS, nrows);
        write_reg(c2csr_pkg::REG_BLOCK_DIM, bdim);
    endtask

    // Load one entry: header plus its words; short blocks only over written words
    task automatic load_entry(logic [11:0] row, logic [11:0] col, int fault);
        int unsigned bs, nw, slot;
        bit ok;
        bs = eff_side() * eff_side();
        send_header(row, col);
        nw = bs;
        if (fault == 1) nw = bs + 1;
        if (fault == 2 && sh_count > 0) begin
            slot = sh_count - 1;
            ok = 1;
            for (int w = bs - 1; w < bs; w++) if (!sh_wrote[slot*SLOT_W + w]) ok = 0;
            if (ok) nw = bs - 1;
        end
        repeat (nw) send_value($urandom);
    endtask

    task automatic read_words(int n);
        repeat (n) send_ctrl(c2csr_pkg::KIND_READ);
    endtask

    function automatic int unsigned total_words();
        return sh_nrows / eff_side() + 1 + sh_count * (1 + eff_side() * eff_side());
    endfunction

    // Edge values, errors and out-of-order loads
    task automatic test_directed();
        send_ctrl(c2csr_pkg::KIND_READ);        // read while loading
        send_ctrl(c2csr_pkg::KIND_CONVERT);     // empty table
        send_value(32'h0);                      // word before any header
        send_header(12'd4095, 12'd4095);
        send_value(32'hFFFF_FFFF);
        send_header(12'd0, 12'd0);
        send_value(32'h0);
        send_header(12'd0, 12'd7);
        send_value(32'hA5A5_5A5A);
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        read_words(3);
        send_value(32'h1234_5678);              // word while reading
        send_header(12'd2, 12'd1);              // fresh load
        send_value(32'h5555_AAAA);
        send_value(32'hAAAA_5555);              // surplus word
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        send_ctrl(c2csr_pkg::KIND_CONVERT);     // sort again
        read_words(4);
        set_shape(3, 1);
        load_entry(12'd2, 12'd3, 0);
        load_entry(12'd1, 12'd9, 0);
        load_entry(12'd3, 12'd0, 0);            // row beyond num_rows
        load_entry(12'd1, 12'd9, 0);            // tie keeps load order
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        read_words(total_words() + 2);          // runs past the end
    endtask

    // Every block side up to the largest, and two sides beyond it
    task automatic test_block_sides();
        int n;
        for (int bd = 0; bd < 16; bd = (bd == 9) ? 15 : bd + 1) begin
            set_shape($urandom_range(1, 40), bd);
            n = (bd <= 4) ? 2 : 1;
            for (int e = 0; e < n; e++)
                load_entry(12'($urandom_range(0, 40)), 12'($urandom), (e == 1) ? 2 : 0);
            send_ctrl(c2csr_pkg::KIND_CONVERT);
            read_words(total_words() + 1);
        end
        // Largest row count, partial read
        set_shape(13'h1FFF, 8);
        load_entry(12'd8, 12'd2, 0);
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        read_words(30);
        set_shape(4096, 1);
        load_entry(12'd4095, 12'd4095, 0);
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        read_words(8);
    endtask

    // More entries than the table holds
    task automatic test_overflow();
        set_shape(16, 1);
        for (int i = 0; i < TABLE_N + 2; i++) load_entry(12'(i / 17), 12'($urandom), 0);
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        read_words(40);
    endtask

    // Long receiver stall while the sender keeps offering
    task automatic test_backpressure();
        set_shape(20, 2);
        for (int e = 0; e < 4; e++)
            load_entry(12'($urandom_range(0, 19)), 12'($urandom), 0);
        send_ctrl(c2csr_pkg::KIND_CONVERT);
        hold_req = 1;
        read_words(total_words());
        drain();
        read_words(2);
    endtask

    // Well-formed sets with random content, with some broken ones
    task automatic test_random(int goal);
        int n, nr, fault;
        while (item_cnt < goal) begin
            if (item_cnt > goal - 250) quiet = 1;
            nr = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 64) : $urandom_range(1, 8191);
            set_shape(nr, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(1, 4));
            n = $urandom_range(1, 8);
            for (int e = 0; e < n; e++) begin
                fault = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
                if ($urandom_range(0, 7) == 0)
                    load_entry(12'($urandom), 12'($urandom), fault);
                else
                    load_entry(12'($urandom_range(0, (nr > 4096 ? 4096 : nr) - 1)),
                               12'($urandom), fault);
            end
            if ($urandom_range(0, 15) == 0) send_value($urandom);
            send_ctrl(c2csr_pkg::KIND_CONVERT);
            if (total_words() < 150) read_words(total_words() + $urandom_range(0, 2));
            else read_words($urandom_range(10, 60));
            if ($urandom_range(0, 7) == 0) send_ctrl(c2csr_pkg::KIND_CONVERT);
        end
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result with the oldest expected word
    always @(posedge aclk) begin
        csr_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result sec=%0d data=%h last=%b err=%b",
                         $time, m_tuser, m_tdata[31:0], m_tlast, m_tdata[32]);
                fail_cnt++;
            end else begin
                want = pending_words.pop_front();
                if (m_tuser !== want.section)
                    $display("%0t: section expected %0d actual %0d", $time, want.section, m_tuser);
                if (m_tdata[31:0] !== want.data)
                    $display("%0t: data expected %h actual %h", $time, want.data, m_tdata[31:0]);
                if (m_tlast !== want.is_last)
                    $display("%0t: is_last expected %b actual %b", $time, want.is_last, m_tlast);
                if (m_tdata[32] !== want.error)
                    $display("%0t: error expected %b actual %b", $time, want.error, m_tdata[32]);
                if (m_tuser !== want.section || m_tdata[31:0] !== want.data ||
                    m_tlast !== want.is_last || m_tdata[32] !== want.error)
                    fail_cnt++;
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("block_coo_to_csr_converter: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        fail_cnt  = 0;
        item_cnt  = 0;
        quiet     = 0;
        hold_req  = 0;
        idle_cycles = 0;
        sh_count = 0; sh_wcount = 0; sh_phase = 0; sh_rpos = 0; sh_cursor = 0;
        sh_err = 0; sh_nrows = 4096; sh_bdim = 1;
        foreach (sh_wrote[i]) sh_wrote[i] = 0;
        foreach (sh_order[i]) sh_order[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_block_sides();
        test_overflow();
        test_backpressure();
        test_random(1850);

        drain();
        if (fail_cnt == 0 && pending_words.size() == 0)
            $display("block_coo_to_csr_converter: match");
        else
            $display("block_coo_to_csr_converter: mismatch");
        $finish;
    end
endmodule
